[src/tmbd_pkg.sv]
// package for the three marker byte deframer
// holds the phase encoding, cell match flags and register reset values; no dependencies
`default_nettype none
package tmbd_pkg;

  localparam int unsigned REG_BYTES = 5;
  localparam int unsigned REG_W     = 8 * REG_BYTES;

  localparam logic [REG_W-1:0] HDR_RESET = 40'h5554535251;
  localparam logic [REG_W-1:0] SEP_RESET = 40'h3536373839;
  localparam logic [REG_W-1:0] TRL_RESET = 40'h2122232425;

  typedef enum logic [1:0] {
    CFG_HDR = 2'd0,
    CFG_SEP = 2'd1,
    CFG_TRL = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_JSON = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef struct packed {
    logic hdr;
    logic sep;
    logic trl;
  } match_t;

endpackage
`default_nettype wire

[src/tmbd_cell.sv]
// one byte cell of the marker window: holds a byte and its fill bit
// compares the byte it takes against the three marker bytes; uses tmbd_pkg
`default_nettype none
module tmbd_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift_en,
  input  wire logic            clear,
  input  wire logic [7:0]      din,
  input  wire logic            vin,
  input  wire logic [7:0]      pat_hdr,
  input  wire logic [7:0]      pat_sep,
  input  wire logic [7:0]      pat_trl,
  output logic      [7:0]      dout,
  output logic                 vout,
  output tmbd_pkg::match_t     match
);

  logic [7:0] byte_r;
  logic       valid_r;

  always_comb begin
    match.hdr = (din == pat_hdr);
    match.sep = (din == pat_sep);
    match.trl = (din == pat_trl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= clear ? 1'b0 : vin;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= din;
    end
  end

  assign dout = byte_r;
  assign vout = valid_r;

endmodule
`default_nettype wire

[src/three_marker_byte_deframer_unit.sv]
// three marker byte deframer: row of byte cells plus frame phase control
// results are registered: each shows in the cycle after the transfer that makes it
// throughput one byte per cycle; the input stalls only while a result waits on a stalled output
// reset clears the window, the phase (hunting) and the output; marker registers take defaults
// depends on tmbd_pkg and tmbd_cell
`default_nettype none
module three_marker_byte_deframer_unit #(
  parameter int unsigned MARKER_BYTES = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_byte_valid,
  output logic [7:0]       out_payload_byte,
  output logic             out_section,
  output logic             out_section_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [tmbd_pkg::REG_W-1:0] cfg_data
);

  localparam int unsigned N = MARKER_BYTES;

  logic [tmbd_pkg::REG_W-1:0] hdr_pat_r, sep_pat_r, trl_pat_r;
  tmbd_pkg::phase_t phase_r, phase_nxt;

  logic [7:0]  dchain [0:N];
  logic [N:0]  vchain;
  logic [N-1:0] hdr_v, sep_v, trl_v;

  logic accept, clear, full, pushed, hit_hdr, hit_sep, hit_trl;
  logic res, res_bv, res_sec, res_end;
  logic [7:0] res_byte;

  logic       out_valid_r, out_valid_nxt;
  logic       bv_r, sec_r, end_r;
  logic [7:0] byte_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pat_r <= tmbd_pkg::HDR_RESET;
      sep_pat_r <= tmbd_pkg::SEP_RESET;
      trl_pat_r <= tmbd_pkg::TRL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tmbd_pkg::CFG_HDR: hdr_pat_r <= cfg_data;
        tmbd_pkg::CFG_SEP: sep_pat_r <= cfg_data;
        tmbd_pkg::CFG_TRL: trl_pat_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign dchain[0] = in_rx_byte;
  assign vchain[0] = 1'b1;

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      logic [7:0] ph, ps, pt;
      tmbd_pkg::match_t m;
      if (i < tmbd_pkg::REG_BYTES) begin : g_pat
        assign ph = hdr_pat_r[8*i +: 8];
        assign ps = sep_pat_r[8*i +: 8];
        assign pt = trl_pat_r[8*i +: 8];
      end else begin : g_zero
        assign ph = 8'h00;
        assign ps = 8'h00;
        assign pt = 8'h00;
      end
      tmbd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (accept),
        .clear    (clear),
        .din      (dchain[i]),
        .vin      (vchain[i]),
        .pat_hdr  (ph),
        .pat_sep  (ps),
        .pat_trl  (pt),
        .dout     (dchain[i+1]),
        .vout     (vchain[i+1]),
        .match    (m)
      );
      assign hdr_v[i] = m.hdr;
      assign sep_v[i] = m.sep;
      assign trl_v[i] = m.trl;
    end
  endgenerate

  // window full after this byte, byte leaving the window
  assign full    = vchain[N-1];
  assign pushed  = vchain[N];
  assign hit_hdr = full && (&hdr_v);
  assign hit_sep = full && (&sep_v) && (phase_r == tmbd_pkg::PH_JSON);
  assign hit_trl = full && (&trl_v) && (phase_r == tmbd_pkg::PH_DATA);

  always_comb begin
    phase_nxt = phase_r;
    clear     = 1'b0;
    res       = 1'b0;
    res_bv    = pushed;
    res_byte  = dchain[N];
    res_sec   = (phase_r == tmbd_pkg::PH_DATA);
    res_end   = 1'b0;
    case (phase_r)
      tmbd_pkg::PH_JSON, tmbd_pkg::PH_DATA: begin
        if (hit_hdr) begin
          clear = 1'b1;
          res   = pushed;
        end else if (hit_sep || hit_trl) begin
          clear     = 1'b1;
          res       = 1'b1;
          res_end   = 1'b1;
          res_byte  = pushed ? dchain[N] : 8'h00;
          phase_nxt = hit_sep ? tmbd_pkg::PH_DATA : tmbd_pkg::PH_HUNT;
        end else begin
          res = pushed;
        end
      end
      default: begin
        phase_nxt = tmbd_pkg::PH_HUNT;
        if (hit_hdr) begin
          clear     = 1'b1;
          phase_nxt = tmbd_pkg::PH_JSON;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tmbd_pkg::PH_HUNT;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept && res) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res) begin
      bv_r   <= res_bv;
      byte_r <= res_byte;
      sec_r  <= res_sec;
      end_r  <= res_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_valid   = bv_r;
  assign out_payload_byte = byte_r;
  assign out_section      = sec_r;
  assign out_section_end  = end_r;

endmodule
`default_nettype wire

[test/tb_three_marker_byte_deframer_unit.sv]
`timescale 1ns / 1ps
// testbench for three_marker_byte_deframer_unit: framed and broken byte streams under
// several marker settings and handshake gap patterns, every result checked in order
// depends on tmbd_pkg and the three_marker_byte_deframer_unit rtl
module tb_three_marker_byte_deframer_unit;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] payload_byte;
    logic       section;
    logic       section_end;
  } deframed_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_rx_byte = 8'h00;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_byte_valid;
  logic [7:0]                 out_payload_byte;
  logic                       out_section;
  logic                       out_section_end;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  tmbd_pkg::cfg_idx_t         cfg_index = tmbd_pkg::CFG_HDR;
  logic [tmbd_pkg::REG_W-1:0] cfg_data = '0;

  logic [7:0] pending_bytes[$];
  deframed_t  expected_out[$];
  int         queued_bytes = 0;
  int         errors = 0;
  int         cycles = 0;
  int         send_gap_pct = 0;
  int         recv_stall_pct = 0;
  logic       recv_hold = 1'b0;
  deframed_t  seen;
  deframed_t  want;

  // deframer model state
  logic [tmbd_pkg::REG_W-1:0] hdr_pat = tmbd_pkg::HDR_RESET;
  logic [tmbd_pkg::REG_W-1:0] sep_pat = tmbd_pkg::SEP_RESET;
  logic [tmbd_pkg::REG_W-1:0] trl_pat = tmbd_pkg::TRL_RESET;
  logic [tmbd_pkg::REG_W-1:0] win = '0;
  int unsigned                win_fill = 0;
  tmbd_pkg::phase_t           frame_ph = tmbd_pkg::PH_HUNT;

  three_marker_byte_deframer_unit #(
    .MARKER_BYTES(tmbd_pkg::REG_BYTES)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_valid   (out_byte_valid),
    .out_payload_byte (out_payload_byte),
    .out_section      (out_section),
    .out_section_end  (out_section_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void deframe_byte(input logic [7:0] b);
    logic             pushed;
    logic [7:0]       old;
    logic             full;
    logic             sec;
    tmbd_pkg::phase_t ph;
    ph = frame_ph;
    pushed = (win_fill >= tmbd_pkg::REG_BYTES);
    old = win[tmbd_pkg::REG_W-1 -: 8];
    if (!pushed) win_fill++;
    win = {win[tmbd_pkg::REG_W-9:0], b};
    full = (win_fill >= tmbd_pkg::REG_BYTES);
    if (full && win == hdr_pat) begin
      win = '0;
      win_fill = 0;
      if (ph == tmbd_pkg::PH_HUNT) begin
        frame_ph = tmbd_pkg::PH_JSON;
      end else if (pushed) begin
        expected_out.push_back(deframed_t'{1'b1, old, ph == tmbd_pkg::PH_DATA, 1'b0});
      end
      return;
    end
    if (ph == tmbd_pkg::PH_HUNT) return;
    sec = (ph == tmbd_pkg::PH_DATA);
    if (full && ((ph == tmbd_pkg::PH_JSON && win == sep_pat) ||
                 (ph == tmbd_pkg::PH_DATA && win == trl_pat))) begin
      win = '0;
      win_fill = 0;
      frame_ph = (ph == tmbd_pkg::PH_JSON) ? tmbd_pkg::PH_DATA : tmbd_pkg::PH_HUNT;
      expected_out.push_back(deframed_t'{pushed, pushed ? old : 8'h00, sec, 1'b1});
      return;
    end
    if (pushed) expected_out.push_back(deframed_t'{1'b1, old, sec, 1'b0});
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) deframe_byte(in_rx_byte);
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_byte_valid, out_payload_byte, out_section, out_section_end};
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected transfer valid=%0b byte=%02h section=%0b end=%0b",
                   $time, seen.byte_valid, seen.payload_byte, seen.section, seen.section_end);
          errors++;
        end else begin
          want = expected_out.pop_front();
          if (seen !== want) begin
            $display("%0t: expected valid=%0b byte=%02h section=%0b end=%0b", $time,
                     want.byte_valid, want.payload_byte, want.section, want.section_end);
            $display("%0t:   actual valid=%0b byte=%02h section=%0b end=%0b", $time,
                     seen.byte_valid, seen.payload_byte, seen.section, seen.section_end);
            errors++;
          end
        end
      end
      out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("three_marker_byte_deframer_unit test failed");
      $finish;
    end
  end

  function automatic logic [tmbd_pkg::REG_W-1:0] rand_pattern();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[tmbd_pkg::REG_W-1:0];
  endfunction

  function automatic int payload_len();
    return ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(6);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_bytes++;
  endtask

  task automatic put_marker(input logic [tmbd_pkg::REG_W-1:0] m);
    for (int i = tmbd_pkg::REG_BYTES - 1; i >= 0; i--) put_byte(m[8*i +: 8]);
  endtask

  task automatic put_noise(input int n);
    for (int i = 0; i < n; i++) put_byte($urandom_range(255));
  endtask

  task automatic add_traffic(input int n);
    int                         stop_at;
    int                         kind;
    int                         k;
    logic [tmbd_pkg::REG_W-1:0] m;
    stop_at = queued_bytes + n;
    while (queued_bytes < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        put_marker(hdr_pat);
        put_noise(payload_len());
        put_marker(sep_pat);
        put_noise(payload_len());
        put_marker(trl_pat);
      end else if (kind < 80) begin
        // misplaced markers inside a frame
        put_marker(hdr_pat);
        put_noise(payload_len());
        put_marker(trl_pat);
        put_marker(hdr_pat);
        put_noise(2);
        put_marker(sep_pat);
        put_marker(sep_pat);
        put_noise(payload_len());
        put_marker(hdr_pat);
        put_marker(trl_pat);
      end else if (kind < 90) begin
        // cut off marker
        k = $urandom_range(2);
        m = (k == 0) ? hdr_pat : (k == 1) ? sep_pat : trl_pat;
        k = $urandom_range(1, tmbd_pkg::REG_BYTES - 1);
        for (int i = 0; i < k; i++) put_byte(m[8*(tmbd_pkg::REG_BYTES-1-i) +: 8]);
        put_noise($urandom_range(1, 4));
      end else begin
        put_noise($urandom_range(1, 10));
      end
    end
  endtask

  task automatic write_reg(input tmbd_pkg::cfg_idx_t idx,
                           input logic [tmbd_pkg::REG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tmbd_pkg::CFG_HDR: hdr_pat = val;
      tmbd_pkg::CFG_SEP: sep_pat = val;
      tmbd_pkg::CFG_TRL: trl_pat = val;
      default: ;
    endcase
  endtask

  task automatic set_pace(input int gap_pct, input int stall_pct);
    @(posedge clk);
    send_gap_pct <= gap_pct;
    recv_stall_pct <= stall_pct;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || expected_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [tmbd_pkg::REG_W-1:0] shared;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // hunting junk, json with extreme bytes, empty data section
    put_byte(8'hff);
    put_byte(8'h00);
    put_marker(hdr_pat);
    put_byte(8'h00);
    put_byte(8'hff);
    put_marker(sep_pat);
    put_marker(trl_pat);
    drain();

    add_traffic(80);
    drain();

    write_reg(tmbd_pkg::CFG_HDR, '1);
    write_reg(tmbd_pkg::CFG_SEP, '0);
    write_reg(tmbd_pkg::CFG_TRL, rand_pattern());
    set_pace(60, 0);
    add_traffic(90);
    drain();

    // header equal to separator
    shared = rand_pattern();
    write_reg(tmbd_pkg::CFG_HDR, shared);
    write_reg(tmbd_pkg::CFG_SEP, shared);
    write_reg(tmbd_pkg::CFG_TRL, rand_pattern());
    set_pace(0, 60);
    add_traffic(90);
    drain();

    // self overlapping markers
    write_reg(tmbd_pkg::CFG_HDR, 40'hAAAAAAAAAA);
    write_reg(tmbd_pkg::CFG_SEP, 40'hAAAAAAAA55);
    write_reg(tmbd_pkg::CFG_TRL, 40'h55AAAAAAAA);
    set_pace(18, 18);
    add_traffic(90);
    drain();

    // long receiver hold-off with the sender at full rate
    write_reg(tmbd_pkg::CFG_HDR, rand_pattern());
    write_reg(tmbd_pkg::CFG_SEP, rand_pattern());
    write_reg(tmbd_pkg::CFG_TRL, rand_pattern());
    set_pace(0, 0);
    fork
      begin
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (300) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join_none
    add_traffic(90);
    drain();

    write_reg(tmbd_pkg::CFG_HDR, tmbd_pkg::HDR_RESET);
    write_reg(tmbd_pkg::CFG_SEP, tmbd_pkg::SEP_RESET);
    write_reg(tmbd_pkg::CFG_TRL, tmbd_pkg::TRL_RESET);
    set_pace(30, 30);
    add_traffic(90);
    drain();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("three_marker_byte_deframer_unit test passed");
    end else begin
      $display("three_marker_byte_deframer_unit test failed");
    end
    $finish;
  end

endmodule

[files.f]
src/tmbd_pkg.sv
src/tmbd_cell.sv
src/three_marker_byte_deframer_unit.sv
test/tb_three_marker_byte_deframer_unit.sv
